### rtl/cnv_pkg.sv
// cnv_pkg: shared types, codes and the fnv-1a-64 step for the container verifier
// used by cnv_stream, cnv_verdict and checksummed_container_verifier
package cnv_pkg;

  localparam int unsigned HDR_BYTES = 48;
  localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;

  localparam logic [2:0] CFG_SCHEMA_LOW  = 3'd0;
  localparam logic [2:0] CFG_SCHEMA_HIGH = 3'd1;
  localparam logic [2:0] CFG_MIN_VERSION = 3'd2;
  localparam logic [2:0] CFG_MAX_VERSION = 3'd3;
  localparam logic [2:0] CFG_MAX_PAYLOAD = 3'd4;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TOO_SMALL = 4'd1;
  localparam logic [3:0] ST_MAGIC     = 4'd2;
  localparam logic [3:0] ST_CONTAINER = 4'd3;
  localparam logic [3:0] ST_SCHEMA    = 4'd4;
  localparam logic [3:0] ST_TOO_OLD   = 4'd5;
  localparam logic [3:0] ST_TOO_NEW   = 4'd6;
  localparam logic [3:0] ST_TOO_LARGE = 4'd7;
  localparam logic [3:0] ST_TRUNCATED = 4'd8;
  localparam logic [3:0] ST_CHECKSUM  = 4'd9;

  typedef struct packed {
    logic [63:0] schema_low;
    logic [63:0] schema_high;
    logic [31:0] min_version;
    logic [31:0] max_version;
    logic [63:0] max_payload_bytes;
  } cfg_t;

  typedef struct packed {
    logic [63:0] byte_count;
    logic        magic_match;
    logic [31:0] container_word;
    logic        schema_match;
    logic [31:0] version_word;
    logic [63:0] length_word;
    logic [63:0] stored_hash;
    logic [63:0] running_hash;
  } snap_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h41;
      3'd1:    b = 8'h43;
      3'd2:    b = 8'h45;
      3'd3:    b = 8'h42;
      3'd4:    b = 8'h49;
      3'd5:    b = 8'h4E;
      3'd6:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // prime 0x100000001B3 as shifted adds
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

### rtl/cnv_stream.sv
// cnv_stream: per-byte header capture, schema/magic compare and running hash
// depends on cnv_pkg
module cnv_stream (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic [7:0]     item_byte,
  input  logic           item_last,
  input  logic           snap_ready,
  input  cnv_pkg::cfg_t  cfg,
  output logic           item_take,
  output logic           snap_load,
  output cnv_pkg::snap_t snap
);

  logic [63:0] byte_count;
  logic        magic_match;
  logic [31:0] container_word;
  logic        schema_match;
  logic [31:0] version_word;
  logic [63:0] length_word;
  logic [63:0] stored_hash;
  logic [63:0] running_hash;

  logic        hdr;
  logic [5:0]  pos;
  logic [4:0]  k;
  logic [63:0] schema_word;
  logic [7:0]  want;
  logic [63:0] byte_count_next;
  logic        magic_match_next;
  logic [31:0] container_word_next;
  logic        schema_match_next;
  logic [31:0] version_word_next;
  logic [63:0] length_word_next;
  logic [63:0] stored_hash_next;
  logic [63:0] running_hash_next;

  assign item_take = item_valid && (!item_last || snap_ready);
  assign snap_load = item_take && item_last;

  assign hdr         = byte_count < 64'(cnv_pkg::HDR_BYTES);
  assign pos         = byte_count[5:0];
  assign k           = pos[4:0] - 5'd12;
  assign schema_word = k[3] ? cfg.schema_high : cfg.schema_low;
  assign want        = schema_word[{k[2:0], 3'b000} +: 8];

  always_comb begin
    byte_count_next     = (&byte_count) ? byte_count : byte_count + 64'd1;
    magic_match_next    = magic_match;
    container_word_next = container_word;
    schema_match_next   = schema_match;
    version_word_next   = version_word;
    length_word_next    = length_word;
    stored_hash_next    = stored_hash;
    running_hash_next   = running_hash;
    if (!hdr) begin
      running_hash_next = cnv_pkg::fnv_step(running_hash, item_byte);
    end else if (pos < 6'd8) begin
      if (item_byte != cnv_pkg::magic_byte(pos[2:0])) magic_match_next = 1'b0;
    end else if (pos < 6'd12) begin
      container_word_next[{pos[1:0], 3'b000} +: 8] = item_byte;
    end else if (pos < 6'd28) begin
      if (item_byte != want) schema_match_next = 1'b0;
    end else if (pos < 6'd32) begin
      version_word_next[{pos[1:0], 3'b000} +: 8] = item_byte;
    end else if (pos < 6'd40) begin
      length_word_next[{pos[2:0], 3'b000} +: 8] = item_byte;
    end else begin
      stored_hash_next[{pos[2:0], 3'b000} +: 8] = item_byte;
    end
  end

  always_comb begin
    snap.byte_count     = byte_count_next;
    snap.magic_match    = magic_match_next;
    snap.container_word = container_word_next;
    snap.schema_match   = schema_match_next;
    snap.version_word   = version_word_next;
    snap.length_word    = length_word_next;
    snap.stored_hash    = stored_hash_next;
    snap.running_hash   = running_hash_next;
  end

  always_ff @(posedge clk) begin
    if (rst || snap_load) begin
      byte_count     <= '0;
      magic_match    <= 1'b1;
      container_word <= '0;
      schema_match   <= 1'b1;
      version_word   <= '0;
      length_word    <= '0;
      stored_hash    <= '0;
      running_hash   <= cnv_pkg::FNV_BASIS;
    end else if (item_take) begin
      byte_count     <= byte_count_next;
      magic_match    <= magic_match_next;
      container_word <= container_word_next;
      schema_match   <= schema_match_next;
      version_word   <= version_word_next;
      length_word    <= length_word_next;
      stored_hash    <= stored_hash_next;
      running_hash   <= running_hash_next;
    end
  end

  // stream state starts over after the last byte
  a_restart: assert property (@(posedge clk) disable iff (rst)
    snap_load |=> (byte_count == '0) && magic_match && schema_match)
    else $error("stream state not cleared after last item");

  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (item_take && !item_last && !(&byte_count)) |=> (byte_count == $past(byte_count) + 64'd1))
    else $error("byte count did not advance");

  a_stall_last: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_last && !snap_ready) |-> !item_take)
    else $error("last item taken while verdict stage full");

endmodule

### rtl/cnv_verdict.sv
// cnv_verdict: end-of-archive snapshot register, priority checks and result register
// depends on cnv_pkg
module cnv_verdict (
  input  logic           clk,
  input  logic           rst,
  input  logic           snap_load,
  input  cnv_pkg::snap_t snap_in,
  input  cnv_pkg::cfg_t  cfg,
  output logic           snap_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [3:0]     status,
  output logic [31:0]    object_version,
  output logic [63:0]    payload_length
);

  logic           snap_valid;
  cnv_pkg::snap_t snap;
  logic           out_free;
  logic [3:0]     status_next;
  logic           too_small;

  assign out_free   = !out_valid || out_ready;
  assign snap_ready = !snap_valid || out_free;
  assign too_small  = snap.byte_count < 64'(cnv_pkg::HDR_BYTES);

  always_comb begin
    if (too_small) begin
      status_next = cnv_pkg::ST_TOO_SMALL;
    end else if (!snap.magic_match) begin
      status_next = cnv_pkg::ST_MAGIC;
    end else if (snap.container_word != 32'd1) begin
      status_next = cnv_pkg::ST_CONTAINER;
    end else if (!snap.schema_match) begin
      status_next = cnv_pkg::ST_SCHEMA;
    end else if (snap.version_word < cfg.min_version) begin
      status_next = cnv_pkg::ST_TOO_OLD;
    end else if (snap.version_word > cfg.max_version) begin
      status_next = cnv_pkg::ST_TOO_NEW;
    end else if (snap.length_word > cfg.max_payload_bytes) begin
      status_next = cnv_pkg::ST_TOO_LARGE;
    end else if (snap.length_word != snap.byte_count - 64'(cnv_pkg::HDR_BYTES)) begin
      status_next = cnv_pkg::ST_TRUNCATED;
    end else if (snap.running_hash != snap.stored_hash) begin
      status_next = cnv_pkg::ST_CHECKSUM;
    end else begin
      status_next = cnv_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_ready) begin
      snap_valid <= snap_load;
    end
    if (snap_ready && snap_load) begin
      snap <= snap_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= snap_valid;
    end
    if (out_free && snap_valid) begin
      status         <= status_next;
      object_version <= too_small ? 32'd0 : snap.version_word;
      payload_length <= too_small ? 64'd0 : snap.length_word;
    end
  end

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= cnv_pkg::ST_CHECKSUM))
    else $error("status code out of range");

  a_small_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == cnv_pkg::ST_TOO_SMALL) |->
      (object_version == '0) && (payload_length == '0))
    else $error("short archive reports header fields");

  a_snap_hold: assert property (@(posedge clk) disable iff (rst)
    (snap_valid && !out_free) |=> snap_valid)
    else $error("pending verdict dropped");

endmodule

### rtl/checksummed_container_verifier.sv
// checksummed_container_verifier: the last byte passes the input, snapshot and result
// registers in turn before its verdict is registered, held while the result is stalled;
// throughput one byte per cycle (the last byte waits while the verdict stage is full),
// set by the fnv-1a-64 update loop; synchronous active-high reset clears all stream
// state, valid flags and config registers to their defaults, but not the data registers;
// no clearing pass. depends on cnv_pkg, cnv_stream, cnv_verdict
module checksummed_container_verifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [31:0] object_version,
  output logic [63:0] payload_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cnv_pkg::cfg_t  cfg;
  cnv_pkg::snap_t snap;
  logic           item_valid;
  logic [7:0]     item_byte;
  logic           item_last;
  logic           item_take;
  logic           snap_load;
  logic           snap_ready;

  assign cfg_ready = 1'b1;
  assign in_ready  = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.schema_low        <= '0;
      cfg.schema_high       <= '0;
      cfg.min_version       <= '0;
      cfg.max_version       <= 32'hFFFF_FFFF;
      cfg.max_payload_bytes <= 64'h0000_0000_FFFF_FFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cnv_pkg::CFG_SCHEMA_LOW:  cfg.schema_low        <= cfg_data;
        cnv_pkg::CFG_SCHEMA_HIGH: cfg.schema_high       <= cfg_data;
        cnv_pkg::CFG_MIN_VERSION: cfg.min_version       <= cfg_data[31:0];
        cnv_pkg::CFG_MAX_VERSION: cfg.max_version       <= cfg_data[31:0];
        cnv_pkg::CFG_MAX_PAYLOAD: cfg.max_payload_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_byte <= data_byte;
      item_last <= last;
    end
  end

  cnv_stream u_stream (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .item_last  (item_last),
    .snap_ready (snap_ready),
    .cfg        (cfg),
    .item_take  (item_take),
    .snap_load  (snap_load),
    .snap       (snap)
  );

  cnv_verdict u_verdict (
    .clk            (clk),
    .rst            (rst),
    .snap_load      (snap_load),
    .snap_in        (snap),
    .cfg            (cfg),
    .snap_ready     (snap_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .object_version (object_version),
    .payload_length (payload_length)
  );

endmodule

### test/cnv_verdict_checker.sv
// cnv_verdict_checker: watches the byte, verdict and register channels of the
// container verifier, predicts each verdict and compares it field by field
// depends on cnv_pkg for the register indexes and verdict codes
module cnv_verdict_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  status,
  input  logic [31:0] object_version,
  input  logic [63:0] payload_length,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          checked,
  output logic [9:0]  codes_seen
);

  localparam logic [63:0] SIG_BYTES = 64'h0001_4E49_4245_4341;
  localparam logic [63:0] HASH_PRIME = 64'd1099511628211;

  typedef struct packed {
    logic [3:0]  code;
    logic [31:0] ver;
    logic [63:0] len;
  } verdict_t;

  verdict_t due_verdicts[$];

  logic [63:0] lim_sch_lo, lim_sch_hi, lim_max_pay;
  logic [31:0] lim_ver_min, lim_ver_max;

  logic [63:0] arc_count;
  logic        sig_ok;
  logic [31:0] cont_word;
  logic        sch_ok;
  logic [31:0] ver_word;
  logic [63:0] len_word;
  logic [63:0] hdr_hash;
  logic [63:0] run_hash;

  function automatic void clear_archive();
    arc_count = '0;
    sig_ok    = 1'b1;
    cont_word = '0;
    sch_ok    = 1'b1;
    ver_word  = '0;
    len_word  = '0;
    hdr_hash  = '0;
    run_hash  = cnv_pkg::FNV_BASIS;
  endfunction

  function automatic void write_limit(input logic [2:0] idx, input logic [63:0] data);
    case (idx)
      cnv_pkg::CFG_SCHEMA_LOW:  lim_sch_lo  = data;
      cnv_pkg::CFG_SCHEMA_HIGH: lim_sch_hi  = data;
      cnv_pkg::CFG_MIN_VERSION: lim_ver_min = data[31:0];
      cnv_pkg::CFG_MAX_VERSION: lim_ver_max = data[31:0];
      cnv_pkg::CFG_MAX_PAYLOAD: lim_max_pay = data;
      default: ;
    endcase
  endfunction

  function automatic void track_byte(input logic [7:0] b, input logic fin);
    int k;
    logic [7:0] want;
    verdict_t v;
    k = int'(arc_count[5:0]);
    if (arc_count < 8) begin
      if (b != SIG_BYTES[8*k +: 8]) sig_ok = 1'b0;
    end else if (arc_count < 12) begin
      cont_word[8*(k-8) +: 8] = b;
    end else if (arc_count < 28) begin
      want = (k < 20) ? lim_sch_lo[8*(k-12) +: 8] : lim_sch_hi[8*(k-20) +: 8];
      if (b != want) sch_ok = 1'b0;
    end else if (arc_count < 32) begin
      ver_word[8*(k-28) +: 8] = b;
    end else if (arc_count < 40) begin
      len_word[8*(k-32) +: 8] = b;
    end else if (arc_count < 64'(cnv_pkg::HDR_BYTES)) begin
      hdr_hash[8*(k-40) +: 8] = b;
    end else begin
      run_hash = (run_hash ^ {56'd0, b}) * HASH_PRIME;
    end
    if (arc_count != '1) arc_count = arc_count + 64'd1;
    if (!fin) return;

    v.ver = '0;
    v.len = '0;
    if (arc_count < 64'(cnv_pkg::HDR_BYTES)) begin
      v.code = cnv_pkg::ST_TOO_SMALL;
    end else begin
      v.ver = ver_word;
      v.len = len_word;
      if (!sig_ok)                     v.code = cnv_pkg::ST_MAGIC;
      else if (cont_word != 32'd1)     v.code = cnv_pkg::ST_CONTAINER;
      else if (!sch_ok)                v.code = cnv_pkg::ST_SCHEMA;
      else if (ver_word < lim_ver_min) v.code = cnv_pkg::ST_TOO_OLD;
      else if (ver_word > lim_ver_max) v.code = cnv_pkg::ST_TOO_NEW;
      else if (len_word > lim_max_pay) v.code = cnv_pkg::ST_TOO_LARGE;
      else if (len_word != arc_count - 64'(cnv_pkg::HDR_BYTES))
                                       v.code = cnv_pkg::ST_TRUNCATED;
      else if (run_hash != hdr_hash)   v.code = cnv_pkg::ST_CHECKSUM;
      else                             v.code = cnv_pkg::ST_OK;
    end
    due_verdicts = {due_verdicts, v};
    codes_seen[v.code] = 1'b1;
    clear_archive();
  endfunction

  function automatic void compare_verdict();
    verdict_t want;
    if (due_verdicts.size() == 0) begin
      $display("%0t: expected no verdict, got status %0d version %0d length %0d",
               $time, status, object_version, payload_length);
      errors++;
      return;
    end
    want = due_verdicts.pop_front();
    checked++;
    if (status !== want.code) begin
      $display("%0t: status expected %0d got %0d", $time, want.code, status);
      errors++;
    end
    if (object_version !== want.ver) begin
      $display("%0t: object_version expected %0d got %0d", $time, want.ver, object_version);
      errors++;
    end
    if (payload_length !== want.len) begin
      $display("%0t: payload_length expected %0d got %0d", $time, want.len, payload_length);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      lim_sch_lo  = '0;
      lim_sch_hi  = '0;
      lim_ver_min = '0;
      lim_ver_max = 32'hFFFF_FFFF;
      lim_max_pay = 64'h0000_0000_FFFF_FFFF;
      clear_archive();
      due_verdicts.delete();
      errors     = 0;
      checked    = 0;
      codes_seen = '0;
    end else begin
      if (out_valid && out_ready) compare_verdict();
      if (cfg_valid && cfg_ready) write_limit(cfg_index, cfg_data);
      if (in_valid && in_ready) track_byte(data_byte, last);
    end
    pending = due_verdicts.size();
  end

endmodule

### test/tb_checksummed_container_verifier.sv
// tb_checksummed_container_verifier: drives framed archives and register settings
// into the container verifier under varied handshake pressure; checking is done by
// cnv_verdict_checker. depends on cnv_pkg and checksummed_container_verifier
module tb_checksummed_container_verifier;

  localparam logic [63:0] SIG_BYTES  = 64'h0001_4E49_4245_4341;
  localparam logic [63:0] HASH_PRIME = 64'd1099511628211;

  localparam int F_MAGIC     = 1;
  localparam int F_CONTAINER = 2;
  localparam int F_SCHEMA    = 4;
  localparam int F_OLD       = 8;
  localparam int F_NEW       = 16;
  localparam int F_LARGE     = 32;
  localparam int F_TRUNC     = 64;
  localparam int F_HASH      = 128;

  localparam int MODE_FREE      = 0;
  localparam int MODE_SEND_IDLE = 1;
  localparam int MODE_RECV_IDLE = 2;
  localparam int MODE_BOTH_IDLE = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        last = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = cnv_pkg::CFG_SCHEMA_LOW;
  logic [63:0] cfg_data = '0;

  logic        in_ready, out_valid, cfg_ready;
  logic [3:0]  status;
  logic [31:0] object_version;
  logic [63:0] payload_length;

  int         errors, pending, checked;
  logic [9:0] codes_seen;

  int send_idle = 0;
  int recv_stall = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  logic [63:0] cur_sch_lo = '0;
  logic [63:0] cur_sch_hi = '0;
  logic [31:0] cur_ver_min = '0;
  logic [31:0] cur_ver_max = 32'hFFFF_FFFF;
  logic [63:0] cur_max_pay = 64'h0000_0000_FFFF_FFFF;

  logic [7:0] archive_bytes[$];
  int bytes_sent = 0;
  int archives_sent = 0;
  int settings_used = 1;

  always #2 clk = ~clk;

  checksummed_container_verifier dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .object_version(object_version), .payload_length(payload_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cnv_verdict_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .object_version(object_version), .payload_length(payload_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .checked(checked), .codes_seen(codes_seen)
  );

  // verdict receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    #1600000;
    $display("checksummed_container_verifier test failed");
    $finish;
  end

  function automatic void add_byte(input logic [7:0] b);
    archive_bytes = {archive_bytes, b};
  endfunction

  task automatic set_idle(input int mode);
    case (mode)
      MODE_FREE:      begin send_idle = 0;  recv_stall = 0;  end
      MODE_SEND_IDLE: begin send_idle = 86; recv_stall = 0;  end
      MODE_RECV_IDLE: begin send_idle = 0;  recv_stall = 86; end
      default:        begin send_idle = 29; recv_stall = 29; end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last      <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_archive();
    foreach (archive_bytes[i]) send_byte(archive_bytes[i], i == archive_bytes.size() - 1);
    archives_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_limits(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [31:0] vmin, input logic [31:0] vmax,
                             input logic [63:0] pay);
    wait_idle();
    write_reg(cnv_pkg::CFG_SCHEMA_LOW, lo);
    write_reg(cnv_pkg::CFG_SCHEMA_HIGH, hi);
    // upper bits of the version registers are don't-care
    write_reg(cnv_pkg::CFG_MIN_VERSION, {32'($urandom), vmin});
    write_reg(cnv_pkg::CFG_MAX_VERSION, {32'($urandom), vmax});
    write_reg(cnv_pkg::CFG_MAX_PAYLOAD, pay);
    cfg_valid   <= 1'b0;
    cur_sch_lo  = lo;
    cur_sch_hi  = hi;
    cur_ver_min = vmin;
    cur_ver_max = vmax;
    cur_max_pay = pay;
    settings_used++;
  endtask

  task automatic build_archive(input int faults, input logic [31:0] ver,
                               input logic [63:0] hdr_len, input int n_pay);
    logic [7:0]  pay[$];
    logic [7:0]  b;
    logic [63:0] digest;
    logic [31:0] cont;
    int k;
    digest = cnv_pkg::FNV_BASIS;
    pay = {};
    for (k = 0; k < n_pay; k++) begin
      b = 8'($urandom);
      pay = {pay, b};
      digest = (digest ^ {56'd0, b}) * HASH_PRIME;
    end
    if (faults & F_HASH) digest ^= {32'($urandom), 32'($urandom)} | 64'd1;
    cont = 32'd1;
    if (faults & F_CONTAINER) begin
      cont = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom);
      if (cont == 32'd1) cont = 32'hFFFF_FFFF;
    end
    archive_bytes = {};
    for (k = 0; k < 8; k++) add_byte(SIG_BYTES[8*k +: 8]);
    if (faults & F_MAGIC) begin
      k = $urandom_range(7);
      archive_bytes[k] ^= 8'd1 << $urandom_range(7);
    end
    for (k = 0; k < 4; k++) add_byte(cont[8*k +: 8]);
    for (k = 0; k < 8; k++) add_byte(cur_sch_lo[8*k +: 8]);
    for (k = 0; k < 8; k++) add_byte(cur_sch_hi[8*k +: 8]);
    if (faults & F_SCHEMA) begin
      k = 12 + $urandom_range(15);
      archive_bytes[k] ^= 8'd1 << $urandom_range(7);
    end
    for (k = 0; k < 4; k++) add_byte(ver[8*k +: 8]);
    for (k = 0; k < 8; k++) add_byte(hdr_len[8*k +: 8]);
    for (k = 0; k < 8; k++) add_byte(digest[8*k +: 8]);
    foreach (pay[i]) add_byte(pay[i]);
  endtask

  task automatic send_built(input int faults, input logic [31:0] ver,
                            input logic [63:0] hdr_len, input int n_pay);
    build_archive(faults, ver, hdr_len, n_pay);
    send_archive();
  endtask

  task automatic trim_archive(input int keep);
    while (archive_bytes.size() > keep) void'(archive_bytes.pop_back());
  endtask

  // well-formed archives and others with one or two faults,
  // cut short, or plain noise
  task automatic random_archive();
    int pick, faults, n, cap;
    logic [31:0] ver, room;
    logic [32:0] span;
    logic [63:0] len;
    pick = $urandom_range(99);
    faults = 0;
    if (pick < 10) begin
      archive_bytes = {};
      repeat ($urandom_range(70, 1)) add_byte(8'($urandom));
      return;
    end
    if (pick >= 55) begin
      faults = 1 << $urandom_range(7);
      if ($urandom_range(1) == 1) faults |= 1 << $urandom_range(7);
    end
    if (cur_ver_min <= cur_ver_max) begin
      case ($urandom_range(3))
        0: ver = cur_ver_min;
        1: ver = cur_ver_max;
        default: begin
          span = {1'b0, cur_ver_max} - {1'b0, cur_ver_min} + 33'd1;
          ver = cur_ver_min + 32'($urandom % span);
        end
      endcase
    end else begin
      ver = $urandom;
    end
    if ((faults & F_OLD) && cur_ver_min != 0) begin
      ver = $urandom % cur_ver_min;
    end else if ((faults & F_NEW) && cur_ver_max != 32'hFFFF_FFFF) begin
      room = ~cur_ver_max;
      ver = cur_ver_max + 32'd1 + $urandom % room;
    end
    cap = (cur_max_pay < 12) ? int'(cur_max_pay) : 12;
    len = 64'($urandom_range(cap, 0));
    n = int'(len);
    if (faults & F_TRUNC) n = (n > 0 && $urandom_range(1) == 1) ? n - 1 : n + 1 + $urandom_range(2);
    if (faults & F_LARGE) begin
      if (cur_max_pay == '1) len = '1;
      else if (cur_max_pay > 64'hFFFF_FFFF_FFFF_FFF0) len = cur_max_pay + 64'd1;
      else len = cur_max_pay + 64'd1 + 64'($urandom_range(3));
      n = $urandom_range(6);
    end
    build_archive(faults, ver, len, n);
    if (pick < 18) trim_archive($urandom_range(47, 1));
  endtask

  initial begin
    int round;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_idle(MODE_FREE);

    // directed archives, reset register values
    send_built(0, 32'd0, 64'd0, 0);
    send_built(0, 32'hFFFF_FFFF, 64'd3, 3);
    archive_bytes = {8'h41};
    send_archive();
    build_archive(0, 32'd3, 64'd2, 2);
    trim_archive(47);
    send_archive();
    send_built(F_MAGIC, 32'd3, 64'd2, 2);
    send_built(F_CONTAINER, 32'd3, 64'd2, 2);
    send_built(F_SCHEMA, 32'd3, 64'd2, 2);
    send_built(F_HASH, 32'd3, 64'd2, 2);
    send_built(0, 32'd7, 64'h1_0000_0000, 2);
    send_built(0, 32'd7, 64'd5, 4);
    send_built(0, 32'd7, 64'd2, 3);
    send_built(F_MAGIC | F_HASH | F_TRUNC, 32'd7, 64'd2, 2);
    send_built(F_SCHEMA | F_HASH, 32'd7, 64'h1_0000_0000, 1);

    load_limits({32'($urandom), 32'($urandom)}, {32'($urandom), 32'($urandom)},
                32'd5, 32'd10, 64'd20);
    send_built(0, 32'd4, 64'd2, 2);
    send_built(0, 32'd11, 64'd2, 2);
    send_built(0, 32'd5, 64'd20, 20);
    send_built(0, 32'd10, 64'd21, 21);

    load_limits('1, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
    send_built(0, 32'hFFFF_FFFF, '1, 2);
    send_built(0, 32'hFFFF_FFFE, 64'd1, 1);

    load_limits('0, '0, 32'd0, 32'd0, '0);
    send_built(0, 32'd0, 64'd0, 0);
    send_built(0, 32'd1, 64'd0, 0);
    send_built(0, 32'd0, 64'd1, 1);

    // verdict side held off while short archives keep coming
    hold_req = 1'b1;
    repeat (30) begin
      archive_bytes = {};
      repeat ($urandom_range(3, 1)) add_byte(8'($urandom));
      send_archive();
    end
    wait_idle();

    round = 0;
    while (bytes_sent < 1950 || round < 8) begin
      case (round % 5)
        0: load_limits('0, '0, 32'd0, 32'hFFFF_FFFF, 64'h0000_0000_FFFF_FFFF);
        1: load_limits({32'($urandom), 32'($urandom)}, {32'($urandom), 32'($urandom)},
                       32'($urandom_range(1000)), 32'($urandom_range(1000)) + 32'd1000,
                       64'($urandom_range(40, 8)));
        2: load_limits('1, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        3: load_limits('0, '0, 32'd0, 32'd0, '0);
        default: load_limits({32'($urandom), 32'($urandom)}, {32'($urandom), 32'($urandom)},
                             32'($urandom), 32'($urandom), 64'($urandom_range(12)));
      endcase
      set_idle(round % 4);
      repeat (4) begin
        random_archive();
        send_archive();
      end
      round++;
    end

    set_idle(MODE_FREE);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("summary: %0d archives, %0d bytes, %0d verdicts checked, %0d register settings",
             archives_sent, bytes_sent, checked, settings_used);
    $display("verdict codes exercised (bit per code): %b", codes_seen);
    if (errors == 0) begin
      $display("checksummed_container_verifier test passed");
    end else begin
      $display("checksummed_container_verifier test failed");
    end
    $finish;
  end

endmodule
